// ===== rtl/itrm_pkg.sv =====
// Shared types and constants for the interface traffic rate meter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package itrm_pkg;

    localparam int KINDS = 3;
    localparam int CMD_W = 2;
    localparam int IF_W = 4;
    localparam int LEN_W = 16;
    localparam int PCNT_W = 32;
    localparam int BCNT_W = 40;
    localparam int RATE_W = 40;
    localparam int INV_W = 24;
    localparam int PER_W = 32;
    localparam int DIV_W = 52;
    localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

    localparam logic [CMD_W-1:0] CMD_RX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

    localparam logic [CMD_W-1:0] KIND_LAST = 2'd2;

    typedef struct packed {
        logic             tick;
        logic [CMD_W-1:0] cmd;
        logic [IF_W-1:0]  port;
        logic [LEN_W-1:0] bytes;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

// ===== rtl/itrm_front.sv =====
// Front end: accepts commands, classifies ticks and queues items for the back end.
// Depends on itrm_pkg.
`timescale 1ns / 1ps

module itrm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [itrm_pkg::CMD_W-1:0] command,
    input  logic [itrm_pkg::IF_W-1:0]  interface_req,
    input  logic [itrm_pkg::LEN_W-1:0] packet_bytes,
    output itrm_pkg::queue_head_t head,
    input  logic                  pop
);
    import itrm_pkg::*;

    item_t       q_reg [2];
    logic        wp_reg;
    logic        wp_next;
    logic        rp_reg;
    logic        rp_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        do_pop;
    item_t       in_item;

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign do_pop = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        in_item.tick = (command == CMD_TICK);
        in_item.cmd = command;
        in_item.port = interface_req;
        in_item.bytes = packet_bytes;
    end

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_item;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item = q_reg[rp_reg];

endmodule

// ===== rtl/itrm_div5.sv =====
// Divider by five that takes sixteen dividend bits per cycle by reciprocal
// multiplication, with 40-bit saturation of the quotient. Depends on itrm_pkg.
`timescale 1ns / 1ps

module itrm_div5 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [itrm_pkg::DIV_W-1:0]    dividend,
    output logic                          done,
    output logic [itrm_pkg::RATE_W-1:0]   quotient
);
    import itrm_pkg::*;

    localparam int CHUNK = 16;
    localparam int STEPS = 4;
    localparam int SH_W = CHUNK * STEPS;
    localparam int TR_W = CHUNK + 3;
    localparam int RECIP_SHIFT = 21;
    localparam logic [TR_W-1:0] RECIP = 19'd419431;
    localparam int CW = $clog2(STEPS + 1);

    logic [SH_W-1:0]   sh_reg;
    logic [SH_W-1:0]   q_reg;
    logic [2:0]        rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [TR_W-1:0]   trial;
    logic [2*TR_W-1:0] prod;
    logic [CHUNK-1:0]  qdig;
    logic [TR_W-1:0]   back_mul;
    logic [TR_W-1:0]   rem_full;
    logic [2:0]        rem_next;

    // The remainder is below five, so each digit of the quotient fits in sixteen bits.
    always_comb
    begin
        trial = {rem_reg, sh_reg[SH_W-1 -: CHUNK]};
        prod = (2*TR_W)'(trial) * (2*TR_W)'(RECIP);
        qdig = prod[RECIP_SHIFT +: CHUNK];
        back_mul = {1'b0, qdig, 2'b00} + {3'b000, qdig};
        rem_full = trial - back_mul;
        rem_next = rem_full[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (go)
            begin
                cnt_reg <= CW'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            sh_reg <= SH_W'(dividend);
            rem_reg <= 3'd0;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg <= {sh_reg[SH_W-CHUNK-1:0], {CHUNK{1'b0}}};
            rem_reg <= rem_next;
            q_reg <= {q_reg[SH_W-CHUNK-1:0], qdig};
        end
    end

    assign done = done_reg;
    assign quotient = (q_reg[SH_W-1:RATE_W] != '0) ? '1 : q_reg[RATE_W-1:0];

endmodule

// ===== rtl/itrm_back.sv =====
// Back end: counter updates for packet events and the smoothing sweep on a tick.
// Depends on itrm_pkg and itrm_div5.
`timescale 1ns / 1ps

module itrm_back #(
    parameter int PORTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itrm_pkg::queue_head_t         head,
    output logic                          pop,
    input  logic [itrm_pkg::INV_W-1:0]    inv_period,
    output logic                          result_valid,
    output logic [itrm_pkg::IF_W-1:0]     port,
    output logic [itrm_pkg::CMD_W-1:0]    kind,
    output logic [itrm_pkg::RATE_W-1:0]   packet_rate,
    output logic [itrm_pkg::RATE_W-1:0]   kilobyte_rate,
    output logic [itrm_pkg::PER_W-1:0]    period_index,
    output logic                          last
);
    import itrm_pkg::*;

    localparam int ENTRIES = PORTS * KINDS;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(PORTS + 1);
    localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int CNT_W = PCNT_W + BCNT_W;
    localparam int HALF = 20;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_DIVW = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [CNT_W-1:0]       cnt_mem [ENTRIES];
    logic [2*RATE_W-1:0]    sm_mem [ENTRIES];
    logic [CNT_W-1:0]       cnt_rd_reg;
    logic [2*RATE_W-1:0]    sm_rd_reg;
    logic [ENTRIES-1:0]     cvalid_reg;
    logic [ENTRIES-1:0]     svalid_reg;
    logic [PORTS-1:0]       seen_reg;
    logic [PER_W-1:0]       period_reg;
    logic [PW-1:0]          p_reg;
    logic [CMD_W-1:0]       k_reg;
    logic [EW-1:0]          e_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [IF_W-1:0]        evport_reg;
    logic [47:0]            pr_reg;
    logic [43:0]            blo_reg;
    logic [45:0]            kr_reg;

    logic                   rd_en;
    logic [EW-1:0]          rd_addr;
    logic [EW-1:0]          ev_addr;
    logic [EW-1:0]          sc_addr;
    logic                   in_range;
    logic [PCNT_W-1:0]      old_pc;
    logic [BCNT_W-1:0]      old_bc;
    logic [PCNT_W-1:0]      new_pc;
    logic [BCNT_W:0]        sum_bc;
    logic [BCNT_W-1:0]      new_bc;
    logic [RATE_W-1:0]      old_pr;
    logic [RATE_W-1:0]      old_kr;
    logic [55:0]            pr_prod;
    logic [43:0]            bhi_prod;
    logic [63:0]            kr_full;
    logic                   div_go;
    logic [DIV_W-1:0]       div_p_in;
    logic [DIV_W-1:0]       div_k_in;
    logic                   div_p_done;
    logic                   div_k_done;
    logic [RATE_W-1:0]      q_p;
    logic [RATE_W-1:0]      q_k;
    logic                   higher_seen;
    logic                   scan_end;

    assign in_range = (32'(head.item.port) < 32'(PORTS));
    assign ev_addr = EW'(32'(head.item.port) * KINDS + 32'(head.item.cmd));
    assign sc_addr = EW'(32'(p_reg) * KINDS + 32'(k_reg));
    assign scan_end = (p_reg == PW'(PORTS));

    always_comb
    begin
        higher_seen = 1'b0;
        for (int i = 0; i < PORTS; i++)
        begin
            if (i > 32'(p_reg) && seen_reg[i])
            begin
                higher_seen = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = sc_addr;
        div_go = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.tick)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (in_range)
                    begin
                        rd_en = 1'b1;
                        rd_addr = ev_addr;
                        state_next = S_WR;
                    end
                end
            end
            S_WR: state_next = S_IDLE;
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_IDLE;
                end
                else if (seen_reg[p_reg[PIW-1:0]])
                begin
                    rd_en = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_DIVS;
            S_DIVS:
            begin
                div_go = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_p_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT: state_next = S_SCAN;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        old_pc = cvalid_reg[e_reg] ? cnt_rd_reg[CNT_W-1:BCNT_W] : '0;
        old_bc = cvalid_reg[e_reg] ? cnt_rd_reg[BCNT_W-1:0] : '0;
        new_pc = (old_pc == '1) ? old_pc : old_pc + PCNT_W'(1);
        sum_bc = {1'b0, old_bc} + (BCNT_W + 1)'(len_reg);
        new_bc = sum_bc[BCNT_W] ? '1 : sum_bc[BCNT_W-1:0];
        old_pr = svalid_reg[e_reg] ? sm_rd_reg[2*RATE_W-1:RATE_W] : '0;
        old_kr = svalid_reg[e_reg] ? sm_rd_reg[RATE_W-1:0] : '0;
        pr_prod = 56'(old_pc) * 56'(inv_period);
        bhi_prod = 44'(old_bc[BCNT_W-1:HALF]) * 44'(inv_period);
        kr_full = {bhi_prod, 20'd0} + 64'(blo_reg);
        div_p_in = DIV_W'({pr_reg, 2'b00}) + DIV_W'(old_pr);
        div_k_in = DIV_W'({kr_reg, 2'b00}) + DIV_W'(old_kr);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cnt_rd_reg <= cnt_mem[rd_addr];
            sm_rd_reg <= sm_mem[rd_addr];
        end
        if (state_reg == S_WR)
        begin
            cnt_mem[e_reg] <= {new_pc, new_bc};
        end
        if (state_reg == S_OUT)
        begin
            sm_mem[e_reg] <= {q_p, q_k};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            e_reg <= rd_addr;
        end
        if (state_reg == S_IDLE)
        begin
            len_reg <= head.item.bytes;
            evport_reg <= head.item.port;
        end
        if (state_reg == S_MUL1)
        begin
            pr_reg <= pr_prod[55:8];
            blo_reg <= 44'(old_bc[HALF-1:0]) * 44'(inv_period);
        end
        if (state_reg == S_MUL2)
        begin
            kr_reg <= kr_full[63:18];
        end
        if (state_reg == S_OUT)
        begin
            port <= IF_W'(p_reg);
            kind <= k_reg;
            packet_rate <= q_p;
            kilobyte_rate <= q_k;
            period_index <= period_reg;
            last <= (k_reg == KIND_LAST) && !higher_seen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cvalid_reg <= '0;
            svalid_reg <= '0;
            seen_reg <= '0;
            period_reg <= '0;
            p_reg <= '0;
            k_reg <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid <= (state_reg == S_OUT);
            if (state_reg == S_IDLE)
            begin
                p_reg <= '0;
                k_reg <= '0;
            end
            if (state_reg == S_WR)
            begin
                cvalid_reg[e_reg] <= 1'b1;
                seen_reg[PIW'(evport_reg)] <= 1'b1;
            end
            if (state_reg == S_SCAN)
            begin
                if (scan_end)
                begin
                    cvalid_reg <= '0;
                    period_reg <= period_reg + PER_W'(1);
                end
                else if (!seen_reg[p_reg[PIW-1:0]])
                begin
                    p_reg <= p_reg + PW'(1);
                end
            end
            if (state_reg == S_OUT)
            begin
                svalid_reg[e_reg] <= 1'b1;
                if (k_reg == KIND_LAST)
                begin
                    k_reg <= '0;
                    p_reg <= p_reg + PW'(1);
                end
                else
                begin
                    k_reg <= k_reg + CMD_W'(1);
                end
            end
        end
    end

    itrm_div5 u_div_p (
        .clk(clk),
        .rst_n(rst_n),
        .go(div_go),
        .dividend(div_p_in),
        .done(div_p_done),
        .quotient(q_p)
    );

    itrm_div5 u_div_k (
        .clk(clk),
        .rst_n(rst_n),
        .go(div_go),
        .dividend(div_k_in),
        .done(div_k_done),
        .quotient(q_k)
    );

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_OUT))
        else $error("result strobe without a report step");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_p_done == div_k_done)
        else $error("dividers out of step");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> $past(state_reg == S_IDLE))
        else $error("counter write without a preceding read");

endmodule

// ===== rtl/interface_traffic_rate_meter_top.sv =====
// Top level of the interface traffic rate meter: configuration register,
// front queue and back sequencer. Depends on itrm_pkg, itrm_front and itrm_back.
`timescale 1ns / 1ps

// A packet event (receive, transmit, drop) on an interface in range is handled
// in the back end by a read of the counter memory and a write of the updated
// count. A tick leaves the queue and then sweeps all interfaces: an unseen one
// is skipped, and a seen one passes, for each of its three kinds, the multiply
// steps, the start of and the wait on the divide-by-five of the smoothing, which
// handles sixteen dividend bits per cycle, and a report step; a final scan step
// ends the sweep. A two-entry queue holds items while the back end works; busy
// is high while it is full. Results appear on the result ports for one cycle
// each, marked by result_valid, and the receiver cannot stall them.
// Counter and rate storage use per-entry valid bits, so no clearing pass is
// needed after reset.
module interface_traffic_rate_meter_top #(
    parameter int PORTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [itrm_pkg::CMD_W-1:0]    command,
    input  logic [itrm_pkg::IF_W-1:0]     interface_req,
    input  logic [itrm_pkg::LEN_W-1:0]    packet_bytes,
    input  logic                          cfg_we,
    input  logic [itrm_pkg::INV_W-1:0]    cfg_wdata,
    output logic                          result_valid,
    output logic [itrm_pkg::IF_W-1:0]     port,
    output logic [itrm_pkg::CMD_W-1:0]    kind,
    output logic [itrm_pkg::RATE_W-1:0]   packet_rate,
    output logic [itrm_pkg::RATE_W-1:0]   kilobyte_rate,
    output logic [itrm_pkg::PER_W-1:0]    period_index,
    output logic                          last
);
    import itrm_pkg::*;

    logic [INV_W-1:0] inv_reg;
    queue_head_t      head;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= INV_RESET;
        end
        else if (cfg_we)
        begin
            inv_reg <= cfg_wdata;
        end
    end

    itrm_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .interface_req(interface_req),
        .packet_bytes(packet_bytes),
        .head(head),
        .pop(pop)
    );

    itrm_back #(
        .PORTS(PORTS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .pop(pop),
        .inv_period(inv_reg),
        .result_valid(result_valid),
        .port(port),
        .kind(kind),
        .packet_rate(packet_rate),
        .kilobyte_rate(kilobyte_rate),
        .period_index(period_index),
        .last(last)
    );

endmodule
